// File: rtl/aggregate_frame_checker_macros.svh
// assertion helpers for the checker rtl
`ifndef AGGREGATE_FRAME_CHECKER_MACROS_SVH
`define AGGREGATE_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/afc_pkg.sv
package afc_pkg;

    localparam int FRAME_BYTES = 136;
    localparam int CRC_SPAN    = 132;
    localparam int NUM_WORDS   = 12;
    localparam int WORD_BASE   = 16;
    localparam int FLAGS_OFS   = 112;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_VER_MAJOR = 2'd0,
        CFG_VER_MINOR = 2'd1,
        CFG_CANON_NAN = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_MAGIC     = 4'd1,
        ST_CRC       = 4'd2,
        ST_VERSION   = 4'd3,
        ST_LENGTH    = 4'd4,
        ST_FLAGS     = 4'd5,
        ST_EXT_FLAGS = 4'd6,
        ST_KEY       = 4'd7,
        ST_EXTREMA   = 4'd8,
        ST_TABLET    = 4'd9,
        ST_AGGREGATE = 4'd10
    } t_status;

    typedef struct packed {
        logic [15:0] ver_major;
        logic [15:0] ver_minor;
        logic [63:0] canon_nan;
    } t_cfg;

    // frame completion info handed from the collector to the output side
    typedef struct packed {
        logic       last_byte;
        t_status    status;
        logic [2:0] flags;
    } t_frame_info;

    typedef logic [63:0] t_word;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h43;
            3'd1:    v = 8'h48;
            3'd2:    v = 8'h44;
            3'd3:    v = 8'h58;
            3'd4:    v = 8'h47;
            3'd5:    v = 8'h52;
            3'd6:    v = 8'h50;
            3'd7:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/afc_collect.sv
module afc_collect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  afc_pkg::t_cfg       i_cfg,
    output afc_pkg::t_frame_info o_info,
    output afc_pkg::t_word      o_words [afc_pkg::NUM_WORDS]
);
    import afc_pkg::*;

    logic [7:0]  r_cnt, n_cnt;
    logic [31:0] r_crc, n_crc;
    logic [55:0] r_asm;
    logic [31:0] r_ver;
    logic [3:0]  r_flags;
    logic        r_magic_bad, n_magic_bad;
    logic        r_len_bad, n_len_bad;
    logic        r_resv_bad, n_resv_bad;
    t_word       r_words [NUM_WORDS];

    logic        first;
    logic        is_last;
    logic [7:0]  wofs;
    logic [31:0] crc_rx;
    logic        bad_byte_len;
    logic        bad_byte_resv;
    logic        has_key, has_ext;
    logic        key_zero_neg, key_nan;
    t_word       key;
    t_status     status;

    assign first   = (r_cnt == 8'd0);
    assign is_last = (r_cnt == 8'(FRAME_BYTES - 1));
    assign wofs    = r_cnt - 8'(WORD_BASE);
    assign crc_rx  = {i_byte, r_asm[55:32]};

    always_comb begin
        case (r_cnt)
            8'd12:   bad_byte_len = (i_byte != 8'(FRAME_BYTES));
            8'd13,
            8'd14,
            8'd15:   bad_byte_len = (i_byte != 8'd0);
            default: bad_byte_len = 1'b0;
        endcase
        if (r_cnt == 8'(FLAGS_OFS)) begin
            bad_byte_resv = (i_byte[7:4] != 4'd0);
        end else if (r_cnt > 8'(FLAGS_OFS) && r_cnt < 8'(CRC_SPAN)) begin
            bad_byte_resv = (i_byte != 8'd0);
        end else begin
            bad_byte_resv = 1'b0;
        end
        n_magic_bad = (first ? 1'b0 : r_magic_bad)
                    | (r_cnt < 8'd8 && i_byte != magic_byte(r_cnt[2:0]));
        n_len_bad   = (first ? 1'b0 : r_len_bad) | bad_byte_len;
        n_resv_bad  = (first ? 1'b0 : r_resv_bad) | bad_byte_resv;
        n_crc       = (r_cnt < 8'(CRC_SPAN)) ? crc_byte(first ? CRC_INIT : r_crc, i_byte)
                                              : r_crc;
        n_cnt       = is_last ? 8'd0 : r_cnt + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 8'd0;
        end else if (i_take) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_crc       <= n_crc;
            r_asm       <= {i_byte, r_asm[55:8]};
            r_magic_bad <= n_magic_bad;
            r_len_bad   <= n_len_bad;
            r_resv_bad  <= n_resv_bad;
            if (r_cnt == 8'd11) begin
                r_ver <= {i_byte, r_asm[55:32]};
            end
            if (r_cnt == 8'(FLAGS_OFS)) begin
                r_flags <= i_byte[3:0];
            end
            if (r_cnt >= 8'(WORD_BASE) && r_cnt < 8'(FLAGS_OFS) && r_cnt[2:0] == 3'd7) begin
                r_words[wofs[6:3]] <= {i_byte, r_asm};
            end
        end
    end

    // frame check in priority order, evaluated as the crc byte arrives
    always_comb begin
        has_key      = r_flags[1];
        has_ext      = r_flags[2];
        key          = r_words[5];
        key_zero_neg = (key[62:0] == 63'd0) && key[63];
        key_nan      = (key[62:52] == 11'h7FF) && (key[51:0] != 52'd0);
        if (r_magic_bad) begin
            status = ST_MAGIC;
        end else if (crc_rx != ~r_crc) begin
            status = ST_CRC;
        end else if (r_ver[15:0] != i_cfg.ver_major || r_ver[31:16] != i_cfg.ver_minor) begin
            status = ST_VERSION;
        end else if (r_len_bad) begin
            status = ST_LENGTH;
        end else if (r_resv_bad) begin
            status = ST_FLAGS;
        end else if (r_flags[2] != r_flags[3]) begin
            status = ST_EXT_FLAGS;
        end else if (!has_key && key != 64'd0) begin
            status = ST_KEY;
        end else if (has_key && (key_zero_neg || (key_nan && key != i_cfg.canon_nan))) begin
            status = ST_KEY;
        end else if (!has_ext && (r_words[8] != 64'd0 || r_words[9] != 64'd0)) begin
            status = ST_EXTREMA;
        end else if (r_words[2] == 64'd0 && r_words[3] == 64'd0) begin
            status = ST_TABLET;
        end else if (r_words[0] == 64'd0 && r_words[1] == 64'd0) begin
            status = ST_AGGREGATE;
        end else if (r_words[4] == 64'd0) begin
            status = ST_AGGREGATE;
        end else if (r_words[6] == 64'd0 && (has_ext || r_words[7] != 64'd0
                     || r_words[10] != 64'd0 || r_words[11] != 64'd0)) begin
            status = ST_AGGREGATE;
        end else if (r_words[6] != 64'd0 && !has_ext) begin
            status = ST_AGGREGATE;
        end else begin
            status = ST_OK;
        end
    end

    assign o_info.last_byte = is_last;
    assign o_info.status    = status;
    assign o_info.flags     = r_flags[2:0];
    assign o_words          = r_words;

endmodule

// File: rtl/afc_out.sv
module afc_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  afc_pkg::t_frame_info i_info,
    input  afc_pkg::t_word       i_words [afc_pkg::NUM_WORDS],
    input  logic                 i_m_tready,
    output logic                 o_failed,
    output logic                 o_busy,
    output logic                 o_load_ok,
    output logic                 o_valid,
    output logic [3:0]           o_status,
    output logic [3:0]           o_word_index,
    output logic [63:0]          o_word,
    output logic [2:0]           o_flags,
    output logic                 o_last
);
    import afc_pkg::*;

    logic        r_failed;
    t_status     r_fail_st;
    logic        r_emit;
    logic [3:0]  r_idx;
    t_word       r_bank [NUM_WORDS];
    logic [2:0]  r_bflags;
    logic        r_ovalid;
    t_status     r_status;
    logic [3:0]  r_windex;
    t_word       r_word;
    logic [2:0]  r_oflags;
    logic        r_last;
    logic        load;
    logic        produce;

    assign load    = !r_ovalid || i_m_tready;
    assign produce = i_take && (r_failed || i_info.last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b0;
            r_emit   <= 1'b0;
            r_idx    <= 4'd0;
            r_ovalid <= 1'b0;
        end else if (r_emit && load) begin
            r_ovalid <= 1'b1;
            r_idx    <= r_idx + 4'd1;
            if (r_idx == 4'(NUM_WORDS - 1)) begin
                r_emit <= 1'b0;
            end
        end else if (produce) begin
            if (!r_failed && i_info.status == ST_OK) begin
                r_emit   <= 1'b1;
                r_idx    <= 4'd0;
                r_ovalid <= 1'b0;
            end else begin
                r_failed <= 1'b1;
                r_ovalid <= 1'b1;
            end
        end else if (load) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit && load) begin
            r_status <= ST_OK;
            r_windex <= r_idx;
            r_word   <= r_bank[r_idx];
            r_oflags <= r_bflags;
            r_last   <= (r_idx == 4'(NUM_WORDS - 1));
        end else if (produce) begin
            if (!r_failed && i_info.status == ST_OK) begin
                r_bank   <= i_words;
                r_bflags <= i_info.flags;
            end else begin
                // error transaction carries only the status
                r_status <= r_failed ? r_fail_st : i_info.status;
                r_windex <= 4'd0;
                r_word   <= 64'd0;
                r_oflags <= 3'd0;
                r_last   <= 1'b1;
                if (!r_failed) begin
                    r_fail_st <= i_info.status;
                end
            end
        end
    end

    assign o_failed     = r_failed;
    assign o_busy       = r_emit;
    assign o_load_ok    = load;
    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_word_index = r_windex;
    assign o_word       = r_word;
    assign o_flags      = r_oflags;
    assign o_last       = r_last;

`include "aggregate_frame_checker_macros.svh"

    `AFC_ASSERT_IMP(a_emit_not_failed, i_clk, i_rst_n, r_emit, !r_failed)
    `AFC_ASSERT_IMP(a_error_zero_word, i_clk, i_rst_n, r_ovalid && r_status != ST_OK,
                    r_last && r_word == 64'd0 && r_oflags == 3'd0)
    `AFC_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, r_emit && load, r_ovalid)
    `AFC_ASSERT_IMP(a_no_produce_while_emit, i_clk, i_rst_n, r_emit, !produce)

endmodule

// File: rtl/aggregate_frame_checker.sv
// aggregate frame checker
// slave stream: one frame byte per transaction in i_s_tdata. bytes gather into
// 136-byte frames; crc-32c runs over the first 132 bytes as they arrive.
// master stream: a good frame yields 12 transactions (identity, sequence, key
// and aggregate words) with the frame flag bits in o_m_tuser and tlast on the
// final word. a bad frame yields one error transaction (status nonzero, tlast
// set); from then on every input byte yields the same error transaction.
// config channel: index 0 major version, 1 minor version, 2 canonical nan
// pattern; always ready, write only while no frame is in progress.
// the closing byte loads the word bank and starts emission; the first word then
// follows from the output register. an error transaction leaves in the cycle after
// its byte. bytes are taken one per cycle; a closing byte (or a byte after failure)
// waits while the previous frame's words are still draining or the output register
// is held by the receiver. while the receiver stalls, the output register holds its
// transaction and non-closing bytes keep flowing in.
// reset clears the byte count, failure state and output valid and loads the
// register defaults.
module aggregate_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] stream_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [3:0] status, [7:4] word_index, [71:8] word
    output logic [2:0]  o_m_tuser,   // [0] terminal, [1] key_present, [2] extrema_present
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import afc_pkg::*;

    t_cfg        r_cfg;
    t_frame_info info;
    t_word       words [NUM_WORDS];
    logic        failed, busy, load_ok;
    logic        produce;
    logic        s_take;
    logic [3:0]  status, windex;
    logic [63:0] word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ver_major <= 16'd1;
            r_cfg.ver_minor <= 16'd0;
            r_cfg.canon_nan <= 64'h7FF8_0000_0000_0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VER_MAJOR: r_cfg.ver_major <= i_cfg_data[15:0];
                CFG_VER_MINOR: r_cfg.ver_minor <= i_cfg_data[15:0];
                CFG_CANON_NAN: r_cfg.canon_nan <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign produce    = failed || info.last_byte;
    assign o_s_tready = !produce || (!busy && load_ok);
    assign s_take     = i_s_tvalid && o_s_tready;

    afc_collect u_collect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s_take && !failed),
        .i_byte  (i_s_tdata),
        .i_cfg   (r_cfg),
        .o_info  (info),
        .o_words (words)
    );

    afc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (s_take),
        .i_info       (info),
        .i_words      (words),
        .i_m_tready   (i_m_tready),
        .o_failed     (failed),
        .o_busy       (busy),
        .o_load_ok    (load_ok),
        .o_valid      (o_m_tvalid),
        .o_status     (status),
        .o_word_index (windex),
        .o_word       (word),
        .o_flags      (o_m_tuser),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {word, windex, status};

endmodule
